>>> rtl/dist_pkg.sv
// Shared types and constants for the dirty interval set tracker.
// No dependencies; imported by every module of the block.
package dist_pkg;

  localparam int MAX_RANGES = 16;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);

  localparam logic [31:0] BOUND_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_BAD_SLOT  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DROP,
    ST_SHUP,
    ST_SHDN,
    ST_DONE
  } state_t;

  // stored bounds (b, e) against key bounds (n, ne)
  typedef struct packed {
    logic b_lt_n;
    logic b_eq_n;
    logic e_lt_n;
    logic e_eq_n;
    logic e_lt_ne;
    logic e_eq_ne;
    logic b_lt_ne;
    logic b_eq_ne;
  } cmp_flags_t;

endpackage

>>> rtl/dist_cmp_unit.sv
// Shared magnitude compare unit: one stored range against key bounds.
// Depends on dist_pkg (cmp_flags_t).
module dist_cmp_unit import dist_pkg::*; (
  input  logic [31:0] old_begin,
  input  logic [31:0] old_end,
  input  logic [31:0] key_begin,
  input  logic [31:0] key_end,
  output cmp_flags_t  flags
);

  always_comb begin
    flags.b_lt_n  = old_begin < key_begin;
    flags.b_eq_n  = old_begin == key_begin;
    flags.e_lt_n  = old_end < key_begin;
    flags.e_eq_n  = old_end == key_begin;
    flags.e_lt_ne = old_end < key_end;
    flags.e_eq_ne = old_end == key_end;
    flags.b_lt_ne = old_begin < key_end;
    flags.b_eq_ne = old_begin == key_end;
  end

endmodule

>>> rtl/dirty_interval_set_tracker.sv
// Dirty interval set tracker: ordered list of half-open ranges with merge.
// Flow: clear, read, unused action and invalid add go straight to the result; insert and
// remove walk every entry, and a remove that drops an entry moves the later entries down;
// add scans the entries, and on a merge drops the entry, moves the later ones down and rescans.
// One word in flight; in_stall is high from accept until the result is registered.
// Synchronous active-low reset empties the list and drops out_valid.
module dirty_interval_set_tracker import dist_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_span_begin,
  input  logic [31:0] in_span_end,
  input  logic [31:0] in_position,
  input  logic [3:0]  in_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_range_begin,
  output logic [31:0] out_range_end,
  output logic [4:0]  out_range_count,
  output logic [1:0]  out_status
);

  logic [31:0] begin_rf [MAX_RANGES];
  logic [31:0] end_rf   [MAX_RANGES];

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic              ret_shdn_r, ret_shdn_nxt;
  logic [31:0]       nb_r, nb_nxt;
  logic [31:0]       ne_r, ne_nxt;
  logic [31:0]       pos_r, pos_nxt;
  logic [31:0]       res_b_r, res_b_nxt;
  logic [31:0]       res_e_r, res_e_nxt;
  status_t           res_st_r, res_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_b_r, out_b_nxt;
  logic [31:0]       out_e_r, out_e_nxt;
  logic [4:0]        out_cnt_r, out_cnt_nxt;
  status_t           out_st_r, out_st_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [31:0]       wr_b, wr_e;
  logic [IDX_W-1:0]  rd_idx;
  logic [31:0]       rd_b, rd_e;
  logic [31:0]       key_b;
  logic [CNT_W-1:0]  j_plus;
  cmp_flags_t        cf;

  logic covers_old, covers_new, touch;
  logic b_ge, e_gt, e_ge;
  logic [31:0] sh_b, sh_e;
  logic accept;

  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign j_plus   = CNT_W'(j_r) + CNT_W'(1);
  assign key_b    = (state_r == ST_SHUP || state_r == ST_SHDN) ? pos_r : nb_r;
  assign rd_b     = begin_rf[rd_idx];
  assign rd_e     = end_rf[rd_idx];

  dist_cmp_unit u_cmp (
    .old_begin (rd_b),
    .old_end   (rd_e),
    .key_begin (key_b),
    .key_end   (ne_r),
    .flags     (cf)
  );

  always_comb begin
    covers_old = (cf.b_lt_n || cf.b_eq_n) && !(cf.e_lt_n || cf.e_eq_n) && !cf.e_lt_ne;
    covers_new = !cf.b_lt_n && cf.b_lt_ne && (cf.e_lt_ne || cf.e_eq_ne);
    touch      = (!cf.b_lt_n && (cf.b_lt_ne || cf.b_eq_ne)) ||
                 ((cf.b_lt_n || cf.b_eq_n) && !cf.e_lt_n);
    b_ge       = !cf.b_lt_n;
    e_gt       = !(cf.e_lt_n || cf.e_eq_n);
    e_ge       = !cf.e_lt_n;
    if (state_r == ST_SHUP) begin
      sh_b = b_ge ? rd_b + 32'd1 : rd_b;
      sh_e = e_gt ? rd_e + 32'd1 : rd_e;
    end else begin
      sh_b = b_ge ? rd_b - 32'd1 : rd_b;
      sh_e = e_ge ? rd_e - 32'd1 : rd_e;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    j_nxt        = j_r;
    ret_shdn_nxt = ret_shdn_r;
    nb_nxt       = nb_r;
    ne_nxt       = ne_r;
    pos_nxt      = pos_r;
    res_b_nxt    = res_b_r;
    res_e_nxt    = res_e_r;
    res_st_nxt   = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_b_nxt    = out_b_r;
    out_e_nxt    = out_e_r;
    out_cnt_nxt  = out_cnt_r;
    out_st_nxt   = out_st_r;
    wr_en        = 1'b0;
    wr_idx       = idx_r[IDX_W-1:0];
    wr_b         = sh_b;
    wr_e         = sh_e;
    rd_idx       = idx_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        rd_idx = IDX_W'(in_slot);
        if (accept) begin
          res_b_nxt  = '0;
          res_e_nxt  = '0;
          res_st_nxt = STAT_OK;
          idx_nxt    = '0;
          nb_nxt     = in_span_begin;
          ne_nxt     = in_span_end;
          pos_nxt    = in_position;
          state_nxt  = ST_DONE;
          case (action_t'(in_action))
            ACT_ADD: begin
              if (in_span_begin >= in_span_end) begin
                res_st_nxt = STAT_BAD_RANGE;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            ACT_INSERT: state_nxt = ST_SHUP;
            ACT_REMOVE: state_nxt = ST_SHDN;
            ACT_CLEAR:  cnt_nxt = '0;
            ACT_READ: begin
              if (32'(in_slot) < 32'(cnt_r)) begin
                res_b_nxt = rd_b;
                res_e_nxt = rd_e;
              end else begin
                res_st_nxt = STAT_BAD_SLOT;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_r == cnt_r) begin
          state_nxt = ST_DONE;
          if (cnt_r == CNT_W'(MAX_RANGES)) begin
            res_st_nxt = STAT_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_idx  = cnt_r[IDX_W-1:0];
            wr_b    = nb_r;
            wr_e    = ne_r;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end else if (covers_old) begin
          state_nxt = ST_DONE;
        end else if (covers_new || touch) begin
          if (!covers_new) begin
            if (cf.b_lt_n) nb_nxt = rd_b;
            if (!(cf.e_lt_ne || cf.e_eq_ne)) ne_nxt = rd_e;
          end
          j_nxt        = idx_r[IDX_W-1:0];
          ret_shdn_nxt = 1'b0;
          state_nxt    = ST_DROP;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_DROP: begin
        rd_idx = j_plus[IDX_W-1:0];
        if (j_plus < cnt_r) begin
          wr_en  = 1'b1;
          wr_idx = j_r;
          wr_b   = rd_b;
          wr_e   = rd_e;
          j_nxt  = j_plus[IDX_W-1:0];
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
          if (ret_shdn_r) begin
            state_nxt = ST_SHDN;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SHUP: begin
        if (idx_r == cnt_r) begin
          state_nxt = ST_DONE;
        end else begin
          wr_en   = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_SHDN: begin
        if (idx_r == cnt_r) begin
          state_nxt = ST_DONE;
        end else if (sh_b == sh_e || sh_b == BOUND_MAX) begin
          j_nxt        = idx_r[IDX_W-1:0];
          ret_shdn_nxt = 1'b1;
          state_nxt    = ST_DROP;
        end else begin
          wr_en   = 1'b1;
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_b_nxt     = res_b_r;
          out_e_nxt     = res_e_r;
          out_cnt_nxt   = 5'(cnt_r);
          out_st_nxt    = res_st_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    j_r        <= j_nxt;
    ret_shdn_r <= ret_shdn_nxt;
    nb_r       <= nb_nxt;
    ne_r       <= ne_nxt;
    pos_r      <= pos_nxt;
    res_b_r    <= res_b_nxt;
    res_e_r    <= res_e_nxt;
    res_st_r   <= res_st_nxt;
    out_b_r    <= out_b_nxt;
    out_e_r    <= out_e_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_st_r   <= out_st_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      begin_rf[wr_idx] <= wr_b;
      end_rf[wr_idx]   <= wr_e;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_range_begin = out_b_r;
  assign out_range_end   = out_e_r;
  assign out_range_count = out_cnt_r;
  assign out_status      = out_st_r;

endmodule

>>> rtl/dist_checker.sv
// Port-level checks for dirty_interval_set_tracker, bound to the top level.
// Depends on dist_pkg (status codes, MAX_RANGES).
module dist_checker import dist_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_range_begin,
  input logic [31:0] out_range_end,
  input logic [4:0]  out_range_count,
  input logic [1:0]  out_status
);

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_range_count <= 5'(MAX_RANGES))
    else $error("range count above list size");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |-> out_range_count == 5'(MAX_RANGES))
    else $error("full status with list not full");

  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_range_begin != 32'd0 || out_range_end != 32'd0))
      |-> out_status == STAT_OK)
    else $error("range data with error status");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_range_begin) &&
      $stable(out_range_end) && $stable(out_range_count) && $stable(out_status)))
    else $error("stalled result word changed");

endmodule

bind dirty_interval_set_tracker dist_checker u_dist_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_range_begin (out_range_begin),
  .out_range_end   (out_range_end),
  .out_range_count (out_range_count),
  .out_status      (out_status)
);
